### sv/tecc_pkg.sv
package tecc_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned CoordW = 16;
    localparam int unsigned NodeW  = 8;
    localparam int unsigned SumW   = 24;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned LnW    = 11;
    localparam int unsigned CompW  = 11;
    localparam int unsigned QuotW  = 11;
    localparam int unsigned RecipW = 17;
    localparam int unsigned RecipShift = 24;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ENABLE      = 3'd0,
        CFG_BLEND_RANGE = 3'd1,
        CFG_COL_FIRST   = 3'd2,
        CFG_COL_LAST    = 3'd3,
        CFG_ROW_FIRST   = 3'd4,
        CFG_ROW_LAST    = 3'd5
    } t_cfg_idx;

    // Register reset values.
    localparam logic             EnableRst     = 1'b1;
    localparam logic [CfgW-1:0]  BlendRangeRst = 16'd512;
    localparam logic [NodeW-1:0] ColFirstRst   = 8'd0;
    localparam logic [NodeW-1:0] ColLastRst    = 8'd63;
    localparam logic [NodeW-1:0] RowFirstRst   = 8'd0;
    localparam logic [NodeW-1:0] RowLastRst    = 8'd39;

    // Edge width thresholds: width <= 64 when outer*255 < 65*inner, and so on.
    localparam logic [7:0] WidthMul  = 8'd255;
    localparam logic [7:0] Seg0Limit = 8'd65;
    localparam logic [7:0] Seg1Limit = 8'd129;

    // Input beat.
    typedef struct packed {
        logic              edge_touch;
        logic              dim_is_x;
        logic [CoordW-1:0] coord_in;
        logic [NodeW-1:0]  bound_near;
        logic [NodeW-1:0]  bound_far;
        logic [NodeW-1:0]  zone_min;
        logic [NodeW-1:0]  zone_max;
        logic [SumW-1:0]   outer_sum;
        logic [SumW-1:0]   inner_sum;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic [CoordW-1:0] coord_out;
        logic              is_edge;
        logic              compensated;
    } t_out;

    // Per-item context that travels down the whole pipeline.
    typedef struct packed {
        logic              is_edge;
        logic              comp_en;
        logic              far;
        logic [CoordW-1:0] base;
        logic [CoordW-1:0] coord;
        logic [CoordW-1:0] raw;
    } t_ctx;

    // Natural log table, Q8.8.
    localparam logic [15:0] LnTable [256] = '{
        16'h0000, 16'h0000, 16'h00B1, 16'h0119, 16'h0162, 16'h019C, 16'h01CA, 16'h01F2,
        16'h0214, 16'h0232, 16'h024D, 16'h0265, 16'h027C, 16'h0290, 16'h02A3, 16'h02B5,
        16'h02C5, 16'h02D5, 16'h02E3, 16'h02F1, 16'h02FE, 16'h030B, 16'h0317, 16'h0322,
        16'h032D, 16'h0338, 16'h0342, 16'h034B, 16'h0355, 16'h035E, 16'h0366, 16'h036F,
        16'h0377, 16'h037F, 16'h0386, 16'h038E, 16'h0395, 16'h039C, 16'h03A3, 16'h03A9,
        16'h03B0, 16'h03B6, 16'h03BC, 16'h03C2, 16'h03C8, 16'h03CE, 16'h03D4, 16'h03D9,
        16'h03DF, 16'h03E4, 16'h03E9, 16'h03EE, 16'h03F3, 16'h03F8, 16'h03FD, 16'h0401,
        16'h0406, 16'h040B, 16'h040F, 16'h0413, 16'h0418, 16'h041C, 16'h0420, 16'h0424,
        16'h0428, 16'h042C, 16'h0430, 16'h0434, 16'h0438, 16'h043B, 16'h043F, 16'h0443,
        16'h0446, 16'h044A, 16'h044D, 16'h0451, 16'h0454, 16'h0458, 16'h045B, 16'h045E,
        16'h0461, 16'h0464, 16'h0468, 16'h046B, 16'h046E, 16'h0471, 16'h0474, 16'h0477,
        16'h047A, 16'h047D, 16'h047F, 16'h0482, 16'h0485, 16'h0488, 16'h048B, 16'h048D,
        16'h0490, 16'h0493, 16'h0495, 16'h0498, 16'h049A, 16'h049D, 16'h049F, 16'h04A2,
        16'h04A4, 16'h04A7, 16'h04A9, 16'h04AC, 16'h04AE, 16'h04B0, 16'h04B3, 16'h04B5,
        16'h04B7, 16'h04BA, 16'h04BC, 16'h04BE, 16'h04C0, 16'h04C3, 16'h04C5, 16'h04C7,
        16'h04C9, 16'h04CB, 16'h04CD, 16'h04CF, 16'h04D1, 16'h04D4, 16'h04D6, 16'h04D8,
        16'h04DA, 16'h04DC, 16'h04DE, 16'h04E0, 16'h04E1, 16'h04E3, 16'h04E5, 16'h04E7,
        16'h04E9, 16'h04EB, 16'h04ED, 16'h04EF, 16'h04F1, 16'h04F2, 16'h04F4, 16'h04F6,
        16'h04F8, 16'h04FA, 16'h04FB, 16'h04FD, 16'h04FF, 16'h0501, 16'h0502, 16'h0504,
        16'h0506, 16'h0507, 16'h0509, 16'h050B, 16'h050C, 16'h050E, 16'h0510, 16'h0511,
        16'h0513, 16'h0514, 16'h0516, 16'h0518, 16'h0519, 16'h051B, 16'h051C, 16'h051E,
        16'h051F, 16'h0521, 16'h0522, 16'h0524, 16'h0525, 16'h0527, 16'h0528, 16'h052A,
        16'h052B, 16'h052D, 16'h052E, 16'h052F, 16'h0531, 16'h0532, 16'h0534, 16'h0535,
        16'h0537, 16'h0538, 16'h0539, 16'h053B, 16'h053C, 16'h053D, 16'h053F, 16'h0540,
        16'h0541, 16'h0543, 16'h0544, 16'h0545, 16'h0547, 16'h0548, 16'h0549, 16'h054B,
        16'h054C, 16'h054D, 16'h054E, 16'h0550, 16'h0551, 16'h0552, 16'h0553, 16'h0555,
        16'h0556, 16'h0557, 16'h0558, 16'h055A, 16'h055B, 16'h055C, 16'h055D, 16'h055E,
        16'h0560, 16'h0561, 16'h0562, 16'h0563, 16'h0564, 16'h0565, 16'h0567, 16'h0568,
        16'h0569, 16'h056A, 16'h056B, 16'h056C, 16'h056D, 16'h056F, 16'h0570, 16'h0571,
        16'h0572, 16'h0573, 16'h0574, 16'h0575, 16'h0576, 16'h0577, 16'h0578, 16'h0579,
        16'h057B, 16'h057C, 16'h057D, 16'h057E, 16'h057F, 16'h0580, 16'h0581, 16'h0582,
        16'h0583, 16'h0584, 16'h0585, 16'h0586, 16'h0587, 16'h0588, 16'h0589, 16'h058A
    };

    // Segment end points, spans and reciprocals of the spans.
    localparam int unsigned Seg0Lo  = LnTable[2];
    localparam int unsigned Seg1Lo  = LnTable[32];
    localparam int unsigned Seg2Lo  = LnTable[96];
    localparam int unsigned Seg0Den = LnTable[32] - LnTable[2];
    localparam int unsigned Seg1Den = LnTable[96] - LnTable[32];
    localparam int unsigned Seg2Den = LnTable[192] - LnTable[96];
    localparam int unsigned Seg0Rcp = (1 << RecipShift) / Seg0Den;
    localparam int unsigned Seg1Rcp = (1 << RecipShift) / Seg1Den;
    localparam int unsigned Seg2Rcp = (1 << RecipShift) / Seg2Den;

    localparam logic [LnW-1:0] SegLo [3] = '{
        LnW'(Seg0Lo), LnW'(Seg1Lo), LnW'(Seg2Lo)
    };
    localparam logic [LnW-1:0] SegDen [3] = '{
        LnW'(Seg0Den), LnW'(Seg1Den), LnW'(Seg2Den)
    };
    localparam logic [RecipW-1:0] SegRcp [3] = '{
        RecipW'(Seg0Rcp), RecipW'(Seg1Rcp), RecipW'(Seg2Rcp)
    };

endpackage

### sv/touch_edge_coordinate_compensator.sv
// Edge coordinate compensator for one axis of one touch contact. A fully pipelined
// datapath takes one beat per clock unless stalled and returns one beat per input
// beat, in order; the depth is set by the 16-step restoring divider that forms the
// blended distance, one quotient bit per stage. A stall on a valid output beat freezes
// the whole pipeline, and o_stall follows it in the same cycle. Configuration writes
// take effect at once and should be made while no beat is in flight.
module touch_edge_coordinate_compensator
    import tecc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_in,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_out
);

    localparam int unsigned DivBits = CoordW;

    // Configuration registers.
    logic             r_enable;
    logic [CfgW-1:0]  r_blend_range;
    logic [NodeW-1:0] r_col_first;
    logic [NodeW-1:0] r_col_last;
    logic [NodeW-1:0] r_row_first;
    logic [NodeW-1:0] r_row_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= EnableRst;
            r_blend_range <= BlendRangeRst;
            r_col_first   <= ColFirstRst;
            r_col_last    <= ColLastRst;
            r_row_first   <= RowFirstRst;
            r_row_last    <= RowLastRst;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:      r_enable      <= i_cfg_data[0];
                CFG_BLEND_RANGE: r_blend_range <= i_cfg_data;
                CFG_COL_FIRST:   r_col_first   <= i_cfg_data[NodeW-1:0];
                CFG_COL_LAST:    r_col_last    <= i_cfg_data[NodeW-1:0];
                CFG_ROW_FIRST:   r_row_first   <= i_cfg_data[NodeW-1:0];
                CFG_ROW_LAST:    r_row_last    <= i_cfg_data[NodeW-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless the output beat is held.
    logic w_ce;
    logic r_out_vld;
    assign w_ce    = !(r_out_vld && i_stall);
    assign o_stall = !w_ce;

    // Stage A: edge decision, raw distance and the edge width products.
    logic              w_near;
    logic              w_far;
    logic [CoordW-1:0] w_bnear;
    logic [CoordW-1:0] w_bfar;
    t_ctx              n_a_ctx;

    always_comb begin
        w_bnear = {i_in.bound_near, 8'h00};
        w_bfar  = {i_in.bound_far, 8'h00};
        w_near  = i_in.zone_min <= (i_in.dim_is_x ? r_col_first : r_row_first);
        w_far   = i_in.zone_max >= (i_in.dim_is_x ? r_col_last : r_row_last);
        n_a_ctx.is_edge = r_enable && i_in.edge_touch;
        n_a_ctx.comp_en = n_a_ctx.is_edge && (w_near || w_far);
        n_a_ctx.far     = w_far;
        n_a_ctx.base    = w_far ? w_bfar : w_bnear;
        n_a_ctx.coord   = i_in.coord_in;
        if (w_far) begin
            n_a_ctx.raw = (w_bfar > i_in.coord_in) ? w_bfar - i_in.coord_in : '0;
        end else begin
            n_a_ctx.raw = (i_in.coord_in > w_bnear) ? i_in.coord_in - w_bnear : '0;
        end
    end

    logic            r_a_vld;
    t_ctx            r_a_ctx;
    logic [31:0]     r_a_outer;
    logic [31:0]     r_a_lim0;
    logic [31:0]     r_a_lim1;
    logic            r_a_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_ce) begin
            r_a_vld <= i_valid;
        end
        if (w_ce) begin
            r_a_ctx   <= n_a_ctx;
            r_a_outer <= i_in.outer_sum * WidthMul;
            r_a_lim0  <= i_in.inner_sum * Seg0Limit;
            r_a_lim1  <= i_in.inner_sum * Seg1Limit;
            r_a_nz    <= i_in.inner_sum != '0;
        end
    end

    // Stage B: segment choice, table lookup and signed distance from the segment start.
    logic [1:0]     n_b_seg;
    logic [LnW-1:0] w_tv;
    logic [LnW:0]   w_diff;
    logic [7:0]     w_idx;

    always_comb begin
        priority if (!r_a_nz || r_a_outer < r_a_lim0) begin
            n_b_seg = 2'd0;
        end else if (r_a_outer < r_a_lim1) begin
            n_b_seg = 2'd1;
        end else begin
            n_b_seg = 2'd2;
        end
        w_idx  = (r_a_ctx.raw > 16'd255) ? 8'hFF : r_a_ctx.raw[7:0];
        w_tv   = LnTable[w_idx][LnW-1:0];
        w_diff = {1'b0, w_tv} - {1'b0, SegLo[n_b_seg]};
    end

    logic           r_b_vld;
    t_ctx           r_b_ctx;
    logic [1:0]     r_b_seg;
    logic           r_b_neg;
    logic [LnW-1:0] r_b_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_ce) begin
            r_b_vld <= r_a_vld;
        end
        if (w_ce) begin
            r_b_ctx <= r_a_ctx;
            r_b_seg <= n_b_seg;
            r_b_neg <= w_diff[LnW];
            r_b_mag <= w_diff[LnW] ? LnW'(-w_diff) : w_diff[LnW-1:0];
        end
    end

    // Stage C: quotient estimate by reciprocal multiplication.
    logic [LnW+7:0]          w_x;
    logic [LnW+RecipW+7:0]   w_qprod;

    assign w_x     = {r_b_mag, 8'h00};
    assign w_qprod = w_x * SegRcp[r_b_seg];

    logic            r_c_vld;
    t_ctx            r_c_ctx;
    logic [1:0]      r_c_seg;
    logic            r_c_neg;
    logic [LnW+7:0]  r_c_x;
    logic [QuotW-1:0] r_c_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_ce) begin
            r_c_vld <= r_b_vld;
        end
        if (w_ce) begin
            r_c_ctx <= r_b_ctx;
            r_c_seg <= r_b_seg;
            r_c_neg <= r_b_neg;
            r_c_x   <= w_x;
            r_c_q   <= w_qprod[RecipShift+QuotW-1:RecipShift];
        end
    end

    // Stage D: correct the estimate by one; comp = 256 - offset (signed, at most 255).
    logic [LnW+8:0]   w_qden;
    logic [LnW+8:0]   w_rem;
    logic [QuotW-1:0] w_q;
    logic [CompW-1:0] n_d_comp;

    always_comb begin
        w_qden = r_c_q * SegDen[r_c_seg];
        w_rem  = {1'b0, r_c_x} - w_qden;
        w_q    = (w_rem >= (LnW+9)'(SegDen[r_c_seg])) ? r_c_q + 1'b1 : r_c_q;
        if (r_c_neg) begin
            n_d_comp = CompW'(256) + w_q;
        end else if (w_q > QuotW'(255)) begin
            n_d_comp = CompW'(1);
        end else begin
            n_d_comp = CompW'(256) - w_q;
        end
    end

    logic             r_d_vld;
    t_ctx             r_d_ctx;
    logic [CompW-1:0] r_d_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_ce) begin
            r_d_vld <= r_c_vld;
        end
        if (w_ce) begin
            r_d_ctx  <= r_c_ctx;
            r_d_comp <= n_d_comp;
        end
    end

    // Stage E1: blend products and the decision whether to blend at all.
    logic [CoordW-1:0] w_gap;
    logic              n_e1_blend;

    always_comb begin
        w_gap      = r_blend_range - r_d_ctx.raw;
        n_e1_blend = !(({5'b0, r_d_comp} >= r_d_ctx.raw) || (r_blend_range == '0) ||
                       (r_d_ctx.raw >= r_blend_range));
    end

    logic                    r_e1_vld;
    t_ctx                    r_e1_ctx;
    logic                    r_e1_blend;
    logic [2*CoordW-1:0]     r_e1_sq;
    logic [CompW+CoordW-1:0] r_e1_cg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
        end else if (w_ce) begin
            r_e1_vld <= r_d_vld;
        end
        if (w_ce) begin
            r_e1_ctx   <= r_d_ctx;
            r_e1_blend <= n_e1_blend;
            r_e1_sq    <= r_d_ctx.raw * r_d_ctx.raw;
            r_e1_cg    <= r_d_comp * w_gap;
        end
    end

    // Stage E2 feeds the divider; without blending the raw distance rides through.
    logic                r_dv_vld   [DivBits+1];
    t_ctx                r_dv_ctx   [DivBits+1];
    logic                r_dv_blend [DivBits+1];
    logic [CoordW-1:0]   r_dv_rem   [DivBits+1];
    logic [CoordW-1:0]   r_dv_lo    [DivBits+1];
    logic [2*CoordW-1:0] w_acc;

    assign w_acc = r_e1_sq + (2*CoordW)'(r_e1_cg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_ce) begin
            r_dv_vld[0] <= r_e1_vld;
        end
        if (w_ce) begin
            r_dv_ctx[0]   <= r_e1_ctx;
            r_dv_blend[0] <= r_e1_blend;
            r_dv_rem[0]   <= r_e1_blend ? w_acc[2*CoordW-1:CoordW] : '0;
            r_dv_lo[0]    <= r_e1_blend ? w_acc[CoordW-1:0] : r_e1_ctx.raw;
        end
    end

    // Restoring divider by the blend range, one quotient bit per stage.
    for (genvar gi = 0; gi < DivBits; gi++) begin : g_div
        logic [CoordW:0] w_t;
        logic            w_ge;

        assign w_t  = {r_dv_rem[gi], r_dv_lo[gi][CoordW-1]};
        assign w_ge = w_t >= {1'b0, r_blend_range};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[gi+1] <= 1'b0;
            end else if (w_ce) begin
                r_dv_vld[gi+1] <= r_dv_vld[gi];
            end
            if (w_ce) begin
                r_dv_ctx[gi+1]   <= r_dv_ctx[gi];
                r_dv_blend[gi+1] <= r_dv_blend[gi];
                if (r_dv_blend[gi]) begin
                    r_dv_rem[gi+1] <= w_ge ? CoordW'(w_t - {1'b0, r_blend_range})
                                           : w_t[CoordW-1:0];
                    r_dv_lo[gi+1]  <= {r_dv_lo[gi][CoordW-2:0], w_ge};
                end else begin
                    r_dv_rem[gi+1] <= r_dv_rem[gi];
                    r_dv_lo[gi+1]  <= r_dv_lo[gi];
                end
            end
        end
    end

    // Output stage: rebuild the coordinate from the boundary.
    t_ctx              w_fc;
    t_out              n_out;
    logic [CoordW-1:0] w_fin;

    always_comb begin
        w_fc  = r_dv_ctx[DivBits];
        w_fin = r_dv_lo[DivBits];
        n_out.is_edge     = w_fc.is_edge;
        n_out.compensated = w_fc.comp_en;
        if (!w_fc.comp_en) begin
            n_out.coord_out = w_fc.coord;
        end else if (w_fc.far) begin
            n_out.coord_out = w_fc.base - w_fin;
        end else begin
            n_out.coord_out = w_fc.base + w_fin;
        end
    end

    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= r_dv_vld[DivBits];
        end
        if (w_ce) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

endmodule

### tb/touch_edge_coordinate_compensator_check.sv
`timescale 1ns / 100ps

module touch_edge_coordinate_compensator_check
    import tecc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  t_in         i_in,
    input  logic        i_valid_out,
    input  logic        i_stall_out,
    input  t_out        i_out,
    output int          o_errors,
    output int          o_pending
);

    // Log table and interpolation segments of the compensation curve.
    localparam logic [15:0] LogCurve [256] = '{
        16'h0000, 16'h0000, 16'h00B1, 16'h0119, 16'h0162, 16'h019C, 16'h01CA, 16'h01F2,
        16'h0214, 16'h0232, 16'h024D, 16'h0265, 16'h027C, 16'h0290, 16'h02A3, 16'h02B5,
        16'h02C5, 16'h02D5, 16'h02E3, 16'h02F1, 16'h02FE, 16'h030B, 16'h0317, 16'h0322,
        16'h032D, 16'h0338, 16'h0342, 16'h034B, 16'h0355, 16'h035E, 16'h0366, 16'h036F,
        16'h0377, 16'h037F, 16'h0386, 16'h038E, 16'h0395, 16'h039C, 16'h03A3, 16'h03A9,
        16'h03B0, 16'h03B6, 16'h03BC, 16'h03C2, 16'h03C8, 16'h03CE, 16'h03D4, 16'h03D9,
        16'h03DF, 16'h03E4, 16'h03E9, 16'h03EE, 16'h03F3, 16'h03F8, 16'h03FD, 16'h0401,
        16'h0406, 16'h040B, 16'h040F, 16'h0413, 16'h0418, 16'h041C, 16'h0420, 16'h0424,
        16'h0428, 16'h042C, 16'h0430, 16'h0434, 16'h0438, 16'h043B, 16'h043F, 16'h0443,
        16'h0446, 16'h044A, 16'h044D, 16'h0451, 16'h0454, 16'h0458, 16'h045B, 16'h045E,
        16'h0461, 16'h0464, 16'h0468, 16'h046B, 16'h046E, 16'h0471, 16'h0474, 16'h0477,
        16'h047A, 16'h047D, 16'h047F, 16'h0482, 16'h0485, 16'h0488, 16'h048B, 16'h048D,
        16'h0490, 16'h0493, 16'h0495, 16'h0498, 16'h049A, 16'h049D, 16'h049F, 16'h04A2,
        16'h04A4, 16'h04A7, 16'h04A9, 16'h04AC, 16'h04AE, 16'h04B0, 16'h04B3, 16'h04B5,
        16'h04B7, 16'h04BA, 16'h04BC, 16'h04BE, 16'h04C0, 16'h04C3, 16'h04C5, 16'h04C7,
        16'h04C9, 16'h04CB, 16'h04CD, 16'h04CF, 16'h04D1, 16'h04D4, 16'h04D6, 16'h04D8,
        16'h04DA, 16'h04DC, 16'h04DE, 16'h04E0, 16'h04E1, 16'h04E3, 16'h04E5, 16'h04E7,
        16'h04E9, 16'h04EB, 16'h04ED, 16'h04EF, 16'h04F1, 16'h04F2, 16'h04F4, 16'h04F6,
        16'h04F8, 16'h04FA, 16'h04FB, 16'h04FD, 16'h04FF, 16'h0501, 16'h0502, 16'h0504,
        16'h0506, 16'h0507, 16'h0509, 16'h050B, 16'h050C, 16'h050E, 16'h0510, 16'h0511,
        16'h0513, 16'h0514, 16'h0516, 16'h0518, 16'h0519, 16'h051B, 16'h051C, 16'h051E,
        16'h051F, 16'h0521, 16'h0522, 16'h0524, 16'h0525, 16'h0527, 16'h0528, 16'h052A,
        16'h052B, 16'h052D, 16'h052E, 16'h052F, 16'h0531, 16'h0532, 16'h0534, 16'h0535,
        16'h0537, 16'h0538, 16'h0539, 16'h053B, 16'h053C, 16'h053D, 16'h053F, 16'h0540,
        16'h0541, 16'h0543, 16'h0544, 16'h0545, 16'h0547, 16'h0548, 16'h0549, 16'h054B,
        16'h054C, 16'h054D, 16'h054E, 16'h0550, 16'h0551, 16'h0552, 16'h0553, 16'h0555,
        16'h0556, 16'h0557, 16'h0558, 16'h055A, 16'h055B, 16'h055C, 16'h055D, 16'h055E,
        16'h0560, 16'h0561, 16'h0562, 16'h0563, 16'h0564, 16'h0565, 16'h0567, 16'h0568,
        16'h0569, 16'h056A, 16'h056B, 16'h056C, 16'h056D, 16'h056F, 16'h0570, 16'h0571,
        16'h0572, 16'h0573, 16'h0574, 16'h0575, 16'h0576, 16'h0577, 16'h0578, 16'h0579,
        16'h057B, 16'h057C, 16'h057D, 16'h057E, 16'h057F, 16'h0580, 16'h0581, 16'h0582,
        16'h0583, 16'h0584, 16'h0585, 16'h0586, 16'h0587, 16'h0588, 16'h0589, 16'h058A
    };
    localparam int WidthLimit [3] = '{64, 128, 255};
    localparam int SpanLo [3]     = '{2, 32, 96};
    localparam int SpanHi [3]     = '{32, 96, 192};

    // Shadow copy of the configuration registers.
    logic        cfg_enable;
    logic [15:0] cfg_blend;
    logic [7:0]  cfg_col_first, cfg_col_last, cfg_row_first, cfg_row_last;

    t_out coord_queue [$];
    int   mismatches;

    assign o_errors  = mismatches;
    assign o_pending = coord_queue.size();

    // Computes the compensated coordinate beat for one contact coordinate.
    function automatic t_out compensate(t_in b);
        t_out      r;
        logic      near_hit, far_hit;
        longint    width, raw, idx, comp, fin, acc, lo, hi, num, ofs, bnear, bfar;
        int        s;
        r.coord_out   = b.coord_in;
        r.is_edge     = 1'b0;
        r.compensated = 1'b0;
        if (!(cfg_enable && b.edge_touch)) return r;
        r.is_edge = 1'b1;
        near_hit = b.zone_min <= (b.dim_is_x ? cfg_col_first : cfg_row_first);
        far_hit  = b.zone_max >= (b.dim_is_x ? cfg_col_last : cfg_row_last);
        if (!near_hit && !far_hit) return r;
        width = 0;
        if (b.inner_sum != 0) begin
            width = longint'(b.outer_sum) * 255 / longint'(b.inner_sum);
            if (width > 255) width = 255;
        end
        bnear = longint'(b.bound_near) * 256;
        bfar  = longint'(b.bound_far) * 256;
        if (far_hit) raw = bfar > b.coord_in ? bfar - b.coord_in : 0;
        else raw = b.coord_in > bnear ? b.coord_in - bnear : 0;
        idx = raw > 255 ? 255 : raw;
        s = 0;
        while (s < 2 && WidthLimit[s] < width) s++;
        lo  = LogCurve[SpanLo[s]];
        hi  = LogCurve[SpanHi[s]];
        num = (longint'(LogCurve[idx]) - lo) * 256;
        // Division truncates toward zero for negative numerators too.
        ofs = num / (hi - lo);
        if (ofs > 255) ofs = 255;
        comp = 256 - ofs;
        if (raw == 0) fin = 0;
        else if (comp >= raw) fin = raw;
        else if (cfg_blend == 0 || raw >= cfg_blend) fin = raw;
        else begin
            acc = raw * raw + comp * (longint'(cfg_blend) - raw);
            fin = acc / cfg_blend;
        end
        r.coord_out   = 16'(far_hit ? bfar - fin : bnear + fin);
        r.compensated = 1'b1;
        return r;
    endfunction

    // Tracks register writes, predicts accepted input beats, checks output beats.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            cfg_enable    <= EnableRst;
            cfg_blend     <= BlendRangeRst;
            cfg_col_first <= ColFirstRst;
            cfg_col_last  <= ColLastRst;
            cfg_row_first <= RowFirstRst;
            cfg_row_last  <= RowLastRst;
            coord_queue.delete();
            mismatches <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ENABLE:      cfg_enable    <= i_cfg_data[0];
                    CFG_BLEND_RANGE: cfg_blend     <= i_cfg_data;
                    CFG_COL_FIRST:   cfg_col_first <= i_cfg_data[7:0];
                    CFG_COL_LAST:    cfg_col_last  <= i_cfg_data[7:0];
                    CFG_ROW_FIRST:   cfg_row_first <= i_cfg_data[7:0];
                    CFG_ROW_LAST:    cfg_row_last  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) coord_queue.push_back(compensate(i_in));
            if (i_valid_out && !i_stall_out) begin
                if (coord_queue.size() == 0) begin
                    if (mismatches < 10) $display("unexpected output beat %h", i_out);
                    mismatches <= mismatches + 1;
                end else begin
                    want = coord_queue.pop_front();
                    if (want !== i_out) begin
                        if (mismatches < 10)
                            $display("mismatch: expected coord %h edge %b comp %b, got %h %b %b",
                                     want.coord_out, want.is_edge, want.compensated,
                                     i_out.coord_out, i_out.is_edge, i_out.compensated);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/touch_edge_coordinate_compensator_test.sv
`timescale 1ns / 100ps

module touch_edge_coordinate_compensator_test
    import tecc_pkg::*;
;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_beat = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_beat;
    int          errors, pending;
    logic        calm = 1'b0;
    logic        hold_go = 1'b0;
    logic        long_hold = 1'b0;
    int          hold_cycles = 0;

    touch_edge_coordinate_compensator dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .o_stall(in_stall), .i_in(in_beat),
        .o_valid(out_valid), .i_stall(out_stall), .o_out(out_beat)
    );

    touch_edge_coordinate_compensator_check checker_inst (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .i_stall_in(in_stall), .i_in(in_beat),
        .i_valid_out(out_valid), .i_stall_out(out_stall), .i_out(out_beat),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls: random bursts, the long hold-off while it runs, none when calm.
    always @(posedge clk) begin
        if (long_hold) begin
            out_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            hold_cycles <= $urandom_range(0, 15);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Long receiver hold-off, started once on request.
    initial begin
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold <= 1'b0;
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits for the pipeline to drain before touching configuration.
    task automatic drain;
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Offers one beat and holds it until accepted; optional random gap before it.
    task automatic send_beat(t_in b);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_sum();
        case ($urandom_range(0, 4))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly edge contacts near a panel boundary, with some fully random noise.
    function automatic t_in rand_contact();
        t_in b;
        b = t_in'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 4) != 0) begin
            b.edge_touch = 1'b1;
            b.inner_sum  = rand_sum();
            b.outer_sum  = rand_sum();
            if ($urandom_range(0, 1)) begin
                b.zone_max = 8'($urandom_range(30, 255));
                b.coord_in = 16'(int'(b.bound_far) * 256 - int'($urandom_range(0, 900)) + 20);
            end else begin
                b.zone_min = 8'($urandom_range(0, 8));
                b.coord_in = 16'(int'(b.bound_near) * 256 + int'($urandom_range(0, 900)) - 20);
            end
        end
        return b;
    endfunction

    function automatic t_in make_contact(logic e, logic x, logic [15:0] c, logic [7:0] bn,
                                         logic [7:0] bf, logic [7:0] zn, logic [7:0] zx,
                                         logic [23:0] o, logic [23:0] n);
        t_in b;
        b.edge_touch = e; b.dim_is_x = x; b.coord_in = c; b.bound_near = bn;
        b.bound_far = bf; b.zone_min = zn; b.zone_max = zx; b.outer_sum = o;
        b.inner_sum = n;
        return b;
    endfunction

    initial begin
        #2000000;
        $display("[touch_edge_coordinate_compensator] ERROR");
        $finish;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed contacts under reset configuration.
        send_beat(make_contact(0, 1, 16'h1234, 0, 63, 0, 63, 100, 100));
        send_beat(make_contact(1, 1, 16'h0080, 0, 63, 0, 10, 10, 100));
        send_beat(make_contact(1, 1, 16'h3E00, 0, 63, 20, 63, 100, 100));
        send_beat(make_contact(1, 0, 16'h2600, 0, 39, 0, 39, 200, 100));
        send_beat(make_contact(1, 0, 16'h1000, 0, 39, 5, 20, 1, 1));
        send_beat(make_contact(1, 1, 16'h0010, 0, 63, 0, 5, 5, 0));
        send_beat(make_contact(1, 1, 16'hFFFF, 0, 63, 40, 255, 24'hFFFFFF, 1));
        send_beat(make_contact(1, 0, 16'h0000, 255, 255, 0, 0, 0, 24'hFFFFFF));
        send_beat(make_contact(1, 1, 16'h0150, 0, 63, 0, 5, 70, 255));
        send_beat(make_contact(1, 1, 16'h0190, 0, 63, 0, 5, 120, 255));
        send_beat(make_contact(1, 1, 16'hFE50, 0, 255, 0, 255, 250, 255));
        in_valid <= 1'b0;
        drain();

        // Blend range zero, disabled, and inverted grid pairs.
        write_reg(CFG_BLEND_RANGE, 16'd0);
        send_beat(make_contact(1, 1, 16'h0150, 0, 63, 0, 5, 70, 255));
        in_valid <= 1'b0;
        drain();
        write_reg(CFG_ENABLE, 16'd0);
        send_beat(make_contact(1, 1, 16'h0150, 0, 63, 0, 5, 70, 255));
        in_valid <= 1'b0;
        drain();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_BLEND_RANGE, 16'hFFFF);
        write_reg(CFG_COL_FIRST, 16'd255);
        write_reg(CFG_COL_LAST, 16'd0);
        write_reg(CFG_ROW_FIRST, 16'd200);
        write_reg(CFG_ROW_LAST, 16'd10);
        send_beat(make_contact(1, 1, 16'h0150, 0, 63, 0, 5, 70, 255));
        send_beat(make_contact(1, 0, 16'h0900, 5, 9, 30, 6, 70, 255));

        // Random phases with fresh register settings between them.
        for (int phase = 0; phase < 6; phase++) begin
            in_valid <= 1'b0;
            drain();
            write_reg(CFG_ENABLE, 16'($urandom_range(0, 5) != 0));
            write_reg(CFG_BLEND_RANGE, phase == 1 ? 16'hFFFF :
                      phase == 2 ? 16'd0 : 16'($urandom_range(1, 1200)));
            write_reg(CFG_COL_FIRST, 16'($urandom_range(0, 8)));
            write_reg(CFG_COL_LAST, 16'($urandom_range(30, 255)));
            write_reg(CFG_ROW_FIRST, 16'($urandom_range(0, 8)));
            write_reg(CFG_ROW_LAST, 16'($urandom_range(30, 255)));
            if (phase == 5) calm <= 1'b1;
            if (phase == 3) hold_go <= 1'b1;
            for (int k = 0; k < 255; k++) send_beat(rand_contact());
        end
        in_valid <= 1'b0;

        drain();
        if (errors == 0) begin
            $display("[touch_edge_coordinate_compensator] OK");
        end else begin
            $display("[touch_edge_coordinate_compensator] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
sv/tecc_pkg.sv
sv/touch_edge_coordinate_compensator.sv
tb/touch_edge_coordinate_compensator_check.sv
tb/touch_edge_coordinate_compensator_test.sv
